// File: sv/twwbc_pkg.sv
// Shared constants for the two-way write-back cache: field widths of the
// stream ports, the access kind code and the bit positions in m_tuser.
// No dependencies.
`default_nettype none

package twwbc_pkg;

    localparam int ADDR_BITS = 12;
    localparam int RD_BITS = 32;
    localparam int M_TUSER_W = 3;

    localparam int HIT_BIT = 0;
    localparam int WB_BIT = 1;
    localparam int WAY_BIT = 2;

    localparam logic KIND_WRITE = 1'b1;

endpackage

`default_nettype wire

// File: sv/twwbc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the backing memory, the tag rows and the line words of each way.
// No dependencies.
`default_nettype none

module twwbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/two_way_write_back_cache.sv
// Top level of the two-way set-associative write-back word cache with its
// own backing memory. Depends on twwbc_pkg and twwbc_ram.
//
//   Channel  Dir  tdata (lowest bit up)              tuser
//   s_       in   address, write_data                kind
//   m_       out  read_data                          hit, wrote_back, way_used
//
// On a hit, the accept cycle reads the tag row and both ways' words, and the
// lookup state compares and reads or writes the word once the output is free.
// A miss fills the line from the backing memory, first writing back the victim
// line when it is dirty; each line word passes a read state and a write state
// through the registered-read line and backing memories.
// After reset the backing memory is cleared word by word with s_tready low.
// A result waits in the output register while the next word is accepted;
// the following result holds the block until the register is free.
`default_nettype none

module two_way_write_back_cache #(
    parameter int WORD_OFFSET_BITS = 2,
    parameter int SET_INDEX_BITS = 4,
    parameter int MEMORY_WORDS = 4096,
    parameter int DATA_BITS = 32,
    localparam int S_TDATA_W = ((twwbc_pkg::ADDR_BITS + DATA_BITS + 7) / 8) * 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [S_TDATA_W-1:0]              s_tdata,   // address, write_data
    input  wire logic                              s_tuser,   // kind
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [twwbc_pkg::RD_BITS-1:0]     m_tdata,   // read_data
    output logic      [twwbc_pkg::M_TUSER_W-1:0]   m_tuser    // hit, wrote_back, way_used
);

    import twwbc_pkg::*;

    localparam int SETS = 1 << SET_INDEX_BITS;
    localparam int WPL = 1 << WORD_OFFSET_BITS;
    localparam int TAG_RAW = ADDR_BITS - WORD_OFFSET_BITS - SET_INDEX_BITS;
    localparam int TAG_BITS = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int OFF_W = (WORD_OFFSET_BITS > 0) ? WORD_OFFSET_BITS : 1;
    localparam int DATA_AW = SET_INDEX_BITS + WORD_OFFSET_BITS;
    localparam int MEM_AW = $clog2(MEMORY_WORDS);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_LOOKUP  = 3'd2;
    localparam logic [2:0] ST_WB_RD   = 3'd3;
    localparam logic [2:0] ST_WB_WR   = 3'd4;
    localparam logic [2:0] ST_FILL_RD = 3'd5;
    localparam logic [2:0] ST_FILL_WR = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    function automatic logic [MEM_AW-1:0] mem_slot(input logic [ADDR_BITS-1:0] a);
        logic [ADDR_BITS-1:0] r;
        logic [20:0] m_k;
        r = a;
        for (int k = 3; k >= 0; k--) begin
            m_k = 21'(MEMORY_WORDS) << k;
            if (21'(r) >= m_k) begin
                r = r - m_k[ADDR_BITS-1:0];
            end
        end
        return MEM_AW'(r);
    endfunction

    function automatic logic [DATA_AW-1:0] line_idx(input logic [SET_INDEX_BITS-1:0] set_i,
                                                    input logic [OFF_W-1:0] off_i);
        return (DATA_AW'(set_i) << WORD_OFFSET_BITS) | DATA_AW'(off_i);
    endfunction

    logic [2:0]               state_reg, state_next;
    logic [OFF_W-1:0]         cnt_reg, cnt_next;
    logic [MEM_AW-1:0]        clr_reg, clr_next;
    logic [SETS-1:0][1:0]     valid_reg, valid_next;
    logic [SETS-1:0][1:0]     dirty_reg, dirty_next;
    logic [SETS-1:0]          oldest_reg, oldest_next;
    logic                     m_valid_reg, m_valid_next;

    logic                     kind_reg;
    logic [ADDR_BITS-1:0]     addr_reg;
    logic [DATA_BITS-1:0]     wdata_reg;
    logic                     way_reg;
    logic                     wb_reg;
    logic [DATA_BITS-1:0]     result_reg;
    logic [RD_BITS-1:0]       m_data_reg;
    logic [M_TUSER_W-1:0]     m_user_reg;

    logic                     accept;
    logic                     out_free;
    logic [ADDR_BITS-1:0]     s_addr;
    logic [DATA_BITS-1:0]     s_wdata;
    logic [SET_INDEX_BITS-1:0] s_set;
    logic [OFF_W-1:0]         s_off;
    logic [SET_INDEX_BITS-1:0] set_idx;
    logic [OFF_W-1:0]         off_idx;
    logic [TAG_BITS-1:0]      req_tag;
    logic [2*TAG_BITS-1:0]    tag_rd;
    logic [TAG_BITS-1:0]      tag0, tag1, victim_tag;
    logic [1:0]               vld, dty;
    logic                     match0, match1, tag_miss, way_sel, hit;
    logic [DATA_BITS-1:0]     d0_rd, d1_rd, hit_word, victim_word, b_rd, fill_word;
    logic                     is_write, cnt_last, load_hit, load_fin, miss_go, fill_wr;
    logic [M_TUSER_W-1:0]     hit_user, fin_user;

    logic                     d_rd_en;
    logic [DATA_AW-1:0]       d_rd_addr, d_wr_addr;
    logic [1:0]               d_wr_en;
    logic [DATA_BITS-1:0]     d_wr_data;
    logic [2*TAG_BITS-1:0]    t_wr_data;
    logic                     b_wr_en, b_rd_en;
    logic [MEM_AW-1:0]        b_wr_addr, b_rd_addr;
    logic [DATA_BITS-1:0]     b_wr_data;
    logic [ADDR_BITS-1:0]     wb_addr, fill_addr;

    assign s_addr = s_tdata[ADDR_BITS-1:0];
    assign s_wdata = s_tdata[ADDR_BITS +: DATA_BITS];
    assign s_set = SET_INDEX_BITS'(s_addr >> WORD_OFFSET_BITS);
    assign s_off = OFF_W'(s_addr & ADDR_BITS'(WPL - 1));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign set_idx = SET_INDEX_BITS'(addr_reg >> WORD_OFFSET_BITS);
    assign off_idx = OFF_W'(addr_reg & ADDR_BITS'(WPL - 1));
    assign req_tag = TAG_BITS'(addr_reg >> (WORD_OFFSET_BITS + SET_INDEX_BITS));
    assign is_write = (kind_reg == KIND_WRITE);

    // A line's tag is only written together with its valid bit; the tag RAM has
    // no reset, so an invalid line's tag is forced to zero here.
    assign vld = valid_reg[set_idx];
    assign dty = dirty_reg[set_idx];
    assign tag0 = vld[0] ? tag_rd[TAG_BITS-1:0] : '0;
    assign tag1 = vld[1] ? tag_rd[2*TAG_BITS-1:TAG_BITS] : '0;
    assign match0 = (tag0 == req_tag);
    assign match1 = (tag1 == req_tag);
    assign tag_miss = !match0 && !match1;
    assign way_sel = match0 ? 1'b0 : (match1 ? 1'b1 : oldest_reg[set_idx]);
    assign hit = !tag_miss && vld[way_sel];
    assign hit_word = way_sel ? d1_rd : d0_rd;

    assign victim_tag = way_reg ? tag_rd[2*TAG_BITS-1:TAG_BITS] : tag_rd[TAG_BITS-1:0];
    assign victim_word = way_reg ? d1_rd : d0_rd;
    assign cnt_last = (cnt_reg == OFF_W'(WPL - 1));
    assign fill_wr = (state_reg == ST_FILL_WR);
    assign fill_word = (is_write && cnt_reg == off_idx) ? wdata_reg : b_rd;

    assign load_hit = (state_reg == ST_LOOKUP) && hit && out_free;
    assign load_fin = (state_reg == ST_FINISH) && out_free;
    assign miss_go = (state_reg == ST_LOOKUP) && !hit;

    assign wb_addr = (ADDR_BITS'(victim_tag) << (WORD_OFFSET_BITS + SET_INDEX_BITS))
                   | (ADDR_BITS'(set_idx) << WORD_OFFSET_BITS) | ADDR_BITS'(cnt_reg);
    assign fill_addr = (addr_reg & ~ADDR_BITS'(WPL - 1)) | ADDR_BITS'(cnt_reg);

    assign d_rd_en = accept || (state_reg == ST_WB_RD);
    assign d_rd_addr = accept ? line_idx(s_set, s_off) : line_idx(set_idx, cnt_reg);
    assign d_wr_en[0] = (load_hit && is_write && !way_sel) || (fill_wr && !way_reg);
    assign d_wr_en[1] = (load_hit && is_write && way_sel) || (fill_wr && way_reg);
    assign d_wr_addr = fill_wr ? line_idx(set_idx, cnt_reg) : line_idx(set_idx, off_idx);
    assign d_wr_data = fill_wr ? fill_word : wdata_reg;

    assign t_wr_data = way_reg ? {req_tag, tag_rd[TAG_BITS-1:0]}
                               : {tag_rd[2*TAG_BITS-1:TAG_BITS], req_tag};

    assign b_wr_en = (state_reg == ST_CLEAR) || (state_reg == ST_WB_WR);
    assign b_wr_addr = (state_reg == ST_CLEAR) ? clr_reg : mem_slot(wb_addr);
    assign b_wr_data = (state_reg == ST_CLEAR) ? '0 : victim_word;
    assign b_rd_en = (state_reg == ST_FILL_RD);
    assign b_rd_addr = mem_slot(fill_addr);

    always_comb begin
        hit_user = '0;
        hit_user[HIT_BIT] = 1'b1;
        hit_user[WAY_BIT] = way_sel;
        fin_user = '0;
        fin_user[WB_BIT] = wb_reg;
        fin_user[WAY_BIT] = way_reg;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        clr_next = clr_reg;
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        oldest_next = oldest_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == MEM_AW'(MEMORY_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cnt_next = '0;
                if (hit) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        if (is_write) begin
                            dirty_next[set_idx][way_sel] = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end else begin
                    if (tag_miss) begin
                        oldest_next[set_idx] = ~oldest_reg[set_idx];
                    end
                    state_next = dty[way_sel] ? ST_WB_RD : ST_FILL_RD;
                end
            end
            ST_WB_RD: begin
                state_next = ST_WB_WR;
            end
            ST_WB_WR: begin
                cnt_next = cnt_last ? '0 : cnt_reg + 1'b1;
                state_next = cnt_last ? ST_FILL_RD : ST_WB_RD;
            end
            ST_FILL_RD: begin
                state_next = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                cnt_next = cnt_reg + 1'b1;
                state_next = cnt_last ? ST_FINISH : ST_FILL_RD;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    valid_next[set_idx][way_reg] = 1'b1;
                    dirty_next[set_idx][way_reg] = is_write;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg <= '0;
            clr_reg <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
            oldest_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            clr_reg <= clr_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            oldest_reg <= oldest_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser;
            addr_reg <= s_addr;
            wdata_reg <= s_wdata;
        end
        if (miss_go) begin
            way_reg <= way_sel;
            wb_reg <= dty[way_sel];
        end
        if (fill_wr && cnt_reg == off_idx) begin
            result_reg <= fill_word;
        end
        if (load_hit) begin
            m_data_reg <= RD_BITS'(is_write ? wdata_reg : hit_word);
            m_user_reg <= hit_user;
        end else if (load_fin) begin
            m_data_reg <= RD_BITS'(result_reg);
            m_user_reg <= fin_user;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_user_reg;

    twwbc_ram #(.WIDTH(DATA_BITS), .DEPTH(MEMORY_WORDS)) u_backing (
        .clk     (aclk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (b_wr_data),
        .rd_en   (b_rd_en),
        .rd_addr (b_rd_addr),
        .rd_data (b_rd)
    );

    twwbc_ram #(.WIDTH(2 * TAG_BITS), .DEPTH(SETS)) u_tags (
        .clk     (aclk),
        .wr_en   (load_fin),
        .wr_addr (set_idx),
        .wr_data (t_wr_data),
        .rd_en   (accept),
        .rd_addr (s_set),
        .rd_data (tag_rd)
    );

    twwbc_ram #(.WIDTH(DATA_BITS), .DEPTH(SETS * WPL)) u_way0 (
        .clk     (aclk),
        .wr_en   (d_wr_en[0]),
        .wr_addr (d_wr_addr),
        .wr_data (d_wr_data),
        .rd_en   (d_rd_en),
        .rd_addr (d_rd_addr),
        .rd_data (d0_rd)
    );

    twwbc_ram #(.WIDTH(DATA_BITS), .DEPTH(SETS * WPL)) u_way1 (
        .clk     (aclk),
        .wr_en   (d_wr_en[1]),
        .wr_addr (d_wr_addr),
        .wr_data (d_wr_data),
        .rd_en   (d_rd_en),
        .rd_addr (d_rd_addr),
        .rd_data (d1_rd)
    );

endmodule

`default_nettype wire

// File: sv/twwbc_check.sv
// Port-level checker for the two-way write-back cache, bound to the top level.
// Depends on twwbc_pkg.
`default_nettype none

module twwbc_check (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [twwbc_pkg::RD_BITS-1:0]     m_tdata,
    input wire logic [twwbc_pkg::M_TUSER_W-1:0]   m_tuser
);

    import twwbc_pkg::*;

    // The backing memory is cleared after reset before any word is taken.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Every access passes through the lookup state, so two words are never taken back to back.
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in the lookup cycle");

    // A new result only appears while the block is busy with an access.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

endmodule

bind two_way_write_back_cache twwbc_check u_twwbc_check (.*);

`default_nettype wire
